// File: rtl/chti_pkg.sv
// ----------------------------------------------------------------------------
// chti_pkg
// Shared constants, command and status codes, and the request/response types
// of the scaled-quotient unit of the cubic Hermite table interpolator.
// ----------------------------------------------------------------------------
package chti_pkg;

  // Default table depth
  localparam int MAX_POINTS_DEF = 64;

  // Fraction bits of the normalized segment position
  localparam int FRAC_S = 26;

  // Width of the Horner accumulator and of the coefficients
  localparam int V_W = 44;

  // Width of a capped quotient magnitude; the cap is 2^40
  localparam int Q_W = 41;
  localparam logic [Q_W-1:0] Q_CAP = Q_W'(64'h0000_0100_0000_0000);

  // Command codes
  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_APPEND = 2'd1;
  localparam logic [1:0] CMD_EVAL   = 2'd2;

  // Status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_FEW   = 2'd2;
  localparam logic [1:0] ST_ORDER = 2'd3;

  // Request to the quotient unit: round(a*b/c), c nonzero
  typedef struct packed {
    logic        start;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
  } md_req_t;

  // Response: capped quotient magnitude, valid while done is high
  typedef struct packed {
    logic           done;
    logic [Q_W-1:0] q;
  } md_rsp_t;

endpackage

// File: rtl/chti_ram.sv
// ----------------------------------------------------------------------------
// chti_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module chti_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/chti_muldiv.sv
// ----------------------------------------------------------------------------
// chti_muldiv
// Scaled quotient unit: one 32x32 product, a half-divisor bias for rounding to
// nearest, then a restoring divide one quotient bit per cycle. The magnitude
// is capped at 2^40.
// ----------------------------------------------------------------------------
module chti_muldiv
  import chti_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  md_req_t req,
  output md_rsp_t rsp
);

  localparam logic [1:0] M_IDLE = 2'd0;
  localparam logic [1:0] M_ADD  = 2'd1;
  localparam logic [1:0] M_DIV  = 2'd2;
  localparam logic [1:0] M_OUT  = 2'd3;

  logic [1:0]  mstate;
  logic [63:0] prod;
  logic [63:0] num;
  logic [31:0] rc;
  logic [31:0] rem;
  logic [5:0]  cnt;
  logic [32:0] rem_sh;
  logic        ge;
  logic [32:0] rem_sub;

  // One restoring step
  assign rem_sh  = {rem, num[63]};
  assign ge      = rem_sh >= {1'b0, rc};
  assign rem_sub = rem_sh - {1'b0, rc};

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      mstate <= M_IDLE;
    end else begin
      case (mstate)
        M_IDLE: if (req.start) mstate <= M_ADD;
        M_ADD:  mstate <= M_DIV;
        M_DIV:  if (cnt == 6'd63) mstate <= M_OUT;
        M_OUT:  mstate <= M_IDLE;
        default: mstate <= M_IDLE;
      endcase
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    case (mstate)
      M_IDLE: begin
        prod <= 64'(req.a) * 64'(req.b);
        rc   <= req.c;
      end
      M_ADD: begin
        num <= prod + 64'(rc >> 1);
        rem <= '0;
        cnt <= '0;
      end
      M_DIV: begin
        rem <= ge ? rem_sub[31:0] : rem_sh[31:0];
        num <= {num[62:0], ge};
        cnt <= cnt + 6'd1;
      end
      default: ;
    endcase
  end

  // Cap and present the quotient
  assign rsp.done = (mstate == M_OUT);
  assign rsp.q    = (num > 64'(Q_CAP)) ? Q_CAP : num[Q_W-1:0];

endmodule

// File: rtl/cubic_hermite_table_interpolator_unit.sv
// ----------------------------------------------------------------------------
// cubic_hermite_table_interpolator_unit
// Knot table in two RAMs with clear, append and evaluate commands. Evaluate
// finds the segment, extrapolates linearly outside the knots, or builds a
// finite-difference cubic Hermite segment and runs Horner's rule in Q1.26.
//
//   channel | handshake            | payload
//   --------+----------------------+-----------------------------------
//   input   | in_valid / in_ready  | command, x_value, y_value
//   output  | out_valid / out_ready| result_value, status, saturated
//
// Clear, append and failed commands go straight to the finish state. Evaluate
// scans one knot per cycle (at most knot_count), loads four knots, sets up,
// then makes passes through the shared quotient unit (one for extrapolation,
// three for a segment) and runs the Horner steps before it finishes and
// returns to idle.
// Reset clears the knot count; RAM data at or above the count is never used.
// A new beat is taken while a finished result waits on a stalled output.
// ----------------------------------------------------------------------------
module cubic_hermite_table_interpolator_unit
  import chti_pkg::*;
#(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         command,
  input  logic signed [31:0] x_value,
  input  logic signed [31:0] y_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] result_value,
  output logic [1:0]         status,
  output logic               saturated
);

  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int AW = $clog2(MAX_POINTS);
  localparam int PW = V_W + 28;
  localparam int HW = V_W - 32 + FRAC_S + 1;
  localparam logic [PW-1:0] HALF = PW'(1) << (FRAC_S - 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SRCH  = 4'd1;
  localparam logic [3:0] S_LOAD  = 4'd2;
  localparam logic [3:0] S_SETUP = 4'd3;
  localparam logic [3:0] S_EXT   = 4'd4;
  localparam logic [3:0] S_TANC  = 4'd5;
  localparam logic [3:0] S_TAND  = 4'd6;
  localparam logic [3:0] S_POS   = 4'd7;
  localparam logic [3:0] S_HMUL  = 4'd8;
  localparam logic [3:0] S_HSUM  = 4'd9;
  localparam logic [3:0] S_HRND  = 4'd10;
  localparam logic [3:0] S_FINAL = 4'd11;
  localparam logic [3:0] S_FIN   = 4'd12;

  function automatic logic signed [32:0] sub33(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
    return {a[31], a} - {b[31], b};
  endfunction

  function automatic logic [31:0] mag33(input logic signed [32:0] v);
    logic signed [32:0] n;
    n = v[32] ? -v : v;
    return n[31:0];
  endfunction

  logic [3:0]          state;
  logic [CW-1:0]       knot_count;
  logic signed [31:0]  last_x;
  logic signed [31:0]  qx;
  logic [CW-1:0]       idx;
  logic [CW-1:0]       base;
  logic [2:0]          lk;
  logic                ext_right;
  logic                ext_mode;
  logic                has_right;
  logic signed [31:0]  kx_m1, kx_0, kx_1, kx_2;
  logic signed [31:0]  ky_m1, ky_0, ky_1, ky_2;
  logic signed [31:0]  ybase;

  logic                ram_we;
  logic [AW-1:0]       rd_addr;
  logic [31:0]         x_rdata;
  logic [31:0]         y_rdata;

  md_req_t             md_req;
  md_rsp_t             md_rsp;
  logic                md_start;
  logic [31:0]         md_a;
  logic [31:0]         md_b;
  logic [31:0]         md_c;
  logic                md_neg;
  logic signed [V_W-1:0] md_mag;
  logic signed [V_W-1:0] sq;

  logic signed [V_W-1:0] c_t, d_t, coef_b, coef_c, v;
  logic [FRAC_S:0]     s;
  logic [1:0]          step;
  logic                vneg;
  logic [58:0]         pp_lo;
  logic [HW-1:0]       pp_hi;
  logic [PW-1:0]       prod;

  logic signed [31:0]  pend_val;
  logic [1:0]          pend_status;
  logic                pend_sat;

  logic                accept;
  logic                full;
  logic                order_bad;
  logic [CW:0]         srch_nxt;
  logic                srch_gt;
  logic                srch_last;
  logic [CW+2:0]       ld_sum;
  logic                has_left_c;
  logic                has_right_c;

  logic signed [32:0]  w_d, h_d, cl_num, cl_den, dr_num, dr_den, t_d, d_d;
  logic [31:0]         w;
  logic signed [V_W-1:0] h_v, a_coef, b_coef, vmag, r_v, addend;
  logic signed [V_W:0] sum_f;
  logic                fits;

  assign accept    = in_valid && in_ready;
  assign in_ready  = (state == S_IDLE);
  assign full      = (knot_count == CW'(MAX_POINTS));
  assign order_bad = (knot_count != '0) && (x_value <= last_x);
  assign ram_we    = accept && (command == CMD_APPEND) && !full && !order_bad;

  // Scan and load addresses
  assign srch_nxt  = (CW + 1)'(idx) + (CW + 1)'(1);
  assign srch_gt   = $signed(x_rdata) < qx;
  assign srch_last = (srch_nxt == (CW + 1)'(knot_count));
  assign ld_sum    = (CW + 3)'(base) + (CW + 3)'(lk) - (CW + 3)'(1);

  always_comb begin
    case (state)
      S_SRCH:  rd_addr = srch_nxt[AW-1:0];
      S_LOAD:  rd_addr = ld_sum[AW-1:0];
      default: rd_addr = '0;
    endcase
  end

  chti_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_ram_x (
    .clk   (clk),
    .we    (ram_we),
    .waddr (knot_count[AW-1:0]),
    .wdata (x_value),
    .raddr (rd_addr),
    .rdata (x_rdata)
  );

  chti_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_ram_y (
    .clk   (clk),
    .we    (ram_we),
    .waddr (knot_count[AW-1:0]),
    .wdata (y_value),
    .raddr (rd_addr),
    .rdata (y_rdata)
  );

  // Pack the quotient request
  assign md_req = {md_start, md_a, md_b, md_c};

  chti_muldiv u_md (
    .clk (clk),
    .rst (rst),
    .req (md_req),
    .rsp (md_rsp)
  );

  // Differences over the loaded knots
  assign w_d    = sub33(kx_1, kx_0);
  assign w      = w_d[31:0];
  assign h_d    = sub33(ky_1, ky_0);
  assign cl_num = sub33(ky_1, ky_m1);
  assign cl_den = sub33(kx_1, kx_m1);
  assign dr_num = sub33(ky_2, ky_0);
  assign dr_den = sub33(kx_2, kx_0);
  assign t_d    = sub33(qx, kx_0);
  assign d_d    = sub33(qx, ext_right ? kx_1 : kx_0);

  assign has_left_c  = (base != '0);
  assign has_right_c = ((CW + 1)'(base) + (CW + 1)'(2)) < (CW + 1)'(knot_count);

  // Signed quotient and Hermite coefficients
  assign md_mag = V_W'(md_rsp.q);
  assign sq     = md_neg ? -md_mag : md_mag;
  assign h_v    = V_W'(h_d);
  assign a_coef = c_t + d_t - (h_v <<< 1);
  assign b_coef = (h_v <<< 1) + h_v - (c_t <<< 1) - d_t;

  // Horner step pieces
  assign vmag = v[V_W-1] ? -v : v;
  assign r_v  = prod[FRAC_S +: V_W];
  always_comb begin
    case (step)
      2'd0:    addend = coef_b;
      2'd1:    addend = coef_c;
      default: addend = '0;
    endcase
  end

  // Final sum and clamp
  assign sum_f = (V_W + 1)'(ybase) + (V_W + 1)'(v);
  assign fits  = (sum_f[V_W:31] == '0) || (sum_f[V_W:31] == '1);

  // Sequencer control
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      knot_count <= '0;
      md_start   <= 1'b0;
    end else begin
      md_start <= (state == S_SETUP) ||
                  ((state == S_TANC || state == S_TAND) && md_rsp.done);
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (command == CMD_EVAL && knot_count >= CW'(2)) state <= S_SRCH;
            else state <= S_FIN;
            case (command)
              CMD_CLEAR:  knot_count <= '0;
              CMD_APPEND: if (ram_we) knot_count <= knot_count + CW'(1);
              default: ;
            endcase
          end
        end
        S_SRCH: begin
          if (!srch_gt || srch_last) state <= S_LOAD;
        end
        S_LOAD: begin
          if (lk == 3'd4) state <= S_SETUP;
        end
        S_SETUP: begin
          state <= ext_mode ? S_EXT : S_TANC;
        end
        S_EXT: begin
          if (md_rsp.done) state <= S_FINAL;
        end
        S_TANC: begin
          if (md_rsp.done) state <= S_TAND;
        end
        S_TAND: begin
          if (md_rsp.done) state <= S_POS;
        end
        S_POS: begin
          if (md_rsp.done) state <= S_HMUL;
        end
        S_HMUL: state <= S_HSUM;
        S_HSUM: state <= S_HRND;
        S_HRND: state <= (step == 2'd2) ? S_FINAL : S_HMUL;
        S_FINAL: state <= S_FIN;
        S_FIN: begin
          if (!out_valid || out_ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Sequencer datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        pend_val    <= '0;
        pend_sat    <= 1'b0;
        qx          <= x_value;
        idx         <= '0;
        if (ram_we) last_x <= x_value;
        if (command == CMD_APPEND && full) pend_status <= ST_FULL;
        else if (command == CMD_APPEND && order_bad) pend_status <= ST_ORDER;
        else if (command == CMD_EVAL && knot_count < CW'(2)) pend_status <= ST_FEW;
        else pend_status <= ST_OK;
      end
      S_SRCH: begin
        lk <= '0;
        if (srch_gt && !srch_last) begin
          idx <= srch_nxt[CW-1:0];
        end else if (srch_gt) begin
          base      <= knot_count - CW'(2);
          ext_mode  <= 1'b1;
          ext_right <= 1'b1;
        end else if (idx == '0) begin
          base      <= '0;
          ext_mode  <= 1'b1;
          ext_right <= 1'b0;
        end else begin
          base      <= idx - CW'(1);
          ext_mode  <= 1'b0;
          ext_right <= 1'b0;
        end
      end
      S_LOAD: begin
        lk <= lk + 3'd1;
        case (lk)
          3'd1: begin kx_m1 <= x_rdata; ky_m1 <= y_rdata; end
          3'd2: begin kx_0  <= x_rdata; ky_0  <= y_rdata; end
          3'd3: begin kx_1  <= x_rdata; ky_1  <= y_rdata; end
          3'd4: begin kx_2  <= x_rdata; ky_2  <= y_rdata; end
          default: ;
        endcase
      end
      S_SETUP: begin
        has_right <= has_right_c;
        if (ext_mode) begin
          ybase  <= ext_right ? ky_1 : ky_0;
          md_a   <= mag33(h_d);
          md_b   <= mag33(d_d);
          md_c   <= w;
          md_neg <= h_d[32] ^ d_d[32];
        end else begin
          ybase <= ky_0;
          md_b  <= w;
          if (has_left_c) begin
            md_a   <= mag33(cl_num);
            md_c   <= cl_den[31:0];
            md_neg <= cl_num[32];
          end else begin
            md_a   <= mag33(h_d);
            md_c   <= w;
            md_neg <= h_d[32];
          end
        end
      end
      S_EXT: begin
        if (md_rsp.done) v <= sq;
      end
      S_TANC: begin
        if (md_rsp.done) begin
          c_t  <= sq;
          md_b <= w;
          if (has_right) begin
            md_a   <= mag33(dr_num);
            md_c   <= dr_den[31:0];
            md_neg <= dr_num[32];
          end else begin
            md_a   <= mag33(h_d);
            md_c   <= w;
            md_neg <= h_d[32];
          end
        end
      end
      S_TAND: begin
        if (md_rsp.done) begin
          d_t    <= sq;
          md_a   <= t_d[31:0];
          md_b   <= 32'(1) << FRAC_S;
          md_c   <= w;
          md_neg <= 1'b0;
        end
      end
      S_POS: begin
        if (md_rsp.done) begin
          s      <= md_rsp.q[FRAC_S:0];
          v      <= a_coef;
          coef_b <= b_coef;
          coef_c <= c_t;
          step   <= '0;
        end
      end
      S_HMUL: begin
        pp_lo <= 59'(vmag[31:0]) * 59'(s);
        pp_hi <= HW'(vmag[V_W-1:32]) * HW'(s);
        vneg  <= v[V_W-1];
      end
      S_HSUM: begin
        prod <= (PW'(pp_hi) << 32) + PW'(pp_lo) + HALF;
      end
      S_HRND: begin
        v    <= addend + (vneg ? -r_v : r_v);
        step <= step + 2'd1;
      end
      S_FINAL: begin
        pend_sat <= !fits;
        if (fits) pend_val <= sum_f[31:0];
        else pend_val <= sum_f[V_W] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end
      default: ;
    endcase
  end

  // Output register: load a finished beat when the slot is free
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_FIN && (!out_valid || out_ready)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FIN && (!out_valid || out_ready)) begin
      result_value <= pend_val;
      status       <= pend_status;
      saturated    <= pend_sat;
    end
  end

endmodule

// File: rtl/chti_checker.sv
// ----------------------------------------------------------------------------
// chti_checker
// Port-level checks on the interpolator: result/status consistency, one
// command in flight, and a stalled output beat holding.
// ----------------------------------------------------------------------------
module chti_checker
  import chti_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic [1:0]         command,
  input logic signed [31:0] x_value,
  input logic signed [31:0] y_value,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [31:0] result_value,
  input logic [1:0]         status,
  input logic               saturated
);

  // Failed commands carry a zero result
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ST_OK) |-> (result_value == 32'sd0))
    else $error("failed command with nonzero result");

  // Saturation only on a good evaluate and only at a range limit
  a_sat_limit: assert property (@(posedge clk) disable iff (rst)
    (out_valid && saturated) |-> (status == ST_OK &&
      (result_value == 32'sh7FFF_FFFF || result_value == 32'sh8000_0000)))
    else $error("saturated flag without a clamped result");

  // One command in flight: no beat taken right after another
  a_one_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken on consecutive cycles");

  // A stalled output beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(result_value) &&
      $stable(status) && $stable(saturated)))
    else $error("stalled output beat changed");

endmodule

bind cubic_hermite_table_interpolator_unit chti_checker u_chti_checker (.*);
